@@ rtl/monotone_chain_convex_hull_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Convex hull unit assertion macros
// Concurrent assertion wrappers shared by the hull unit modules; they expand
// to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef MONOTONE_CHAIN_CONVEX_HULL_UNIT_MACROS_SVH
`define MONOTONE_CHAIN_CONVEX_HULL_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition implies a consequence at every enabled edge
`define CHC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hull unit implication check failed");

// Check that a condition never occurs
`define CHC_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("hull unit forbidden condition seen");

`else

`define CHC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define CHC_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

@@ rtl/chc_pkg.sv @@
// ----------------------------------------------------------------------------
// Convex hull unit package
// Sizes, point and queue word types shared by the hull unit modules.
// ----------------------------------------------------------------------------
package chc_pkg;

   localparam int MAX_POINTS   = 32;
   localparam int COORD_BITS   = 16;
   localparam int STACK_DEPTH  = 2 * MAX_POINTS;

   localparam int PT_IDX_BITS  = $clog2(MAX_POINTS);
   localparam int PT_CNT_BITS  = $clog2(MAX_POINTS + 1);
   localparam int STK_IDX_BITS = $clog2(STACK_DEPTH);
   localparam int STK_CNT_BITS = $clog2(STACK_DEPTH + 1);

   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * DIFF_BITS;
   localparam int POINT_BITS   = 2 * COORD_BITS;

   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   // One classified input word on its way to the hull engine
   typedef struct packed {
      point_type pt;
      logic      last;
      logic      keep;
   } entry_type;

endpackage

@@ rtl/chc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module chc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/chc_front.sv @@
// ----------------------------------------------------------------------------
// Hull unit front end
// Accepts input points and marks each one as kept or dropped by capacity.
// ----------------------------------------------------------------------------
module chc_front
   import chc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  coord_type req_px,
   input  coord_type req_py,
   input  logic      req_final_point,
   output logic      q_valid,
   input  logic      q_ready,
   output entry_type q_entry
);

   logic [PT_CNT_BITS-1:0] cnt_ff;
   logic                   keep;
   logic                   accept;

   assign keep      = (cnt_ff < PT_CNT_BITS'(MAX_POINTS));
   assign accept    = req_valid && q_ready;
   assign req_ready = q_ready;
   assign q_valid   = req_valid;

   // Build the classified word
   always_comb begin
      q_entry.pt.x = req_px;
      q_entry.pt.y = req_py;
      q_entry.last = req_final_point;
      q_entry.keep = keep;
   end

   // Track points of the current set; restart at the last point
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (accept) begin
         if (req_final_point) begin
            cnt_ff <= '0;
         end else if (keep) begin
            cnt_ff <= cnt_ff + PT_CNT_BITS'(1);
         end
      end
   end

endmodule

@@ rtl/chc_queue.sv @@
// ----------------------------------------------------------------------------
// Hull unit word queue
// Short register queue between the front end and the hull engine.
// ----------------------------------------------------------------------------
`include "monotone_chain_convex_hull_unit_macros.svh"

module chc_queue
   import chc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  entry_type in_entry,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_entry
);

   entry_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QCNT_BITS-1:0] cnt_ff;
   logic                 push;
   logic                 pop;

   assign in_ready  = (cnt_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_entry = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Store incoming words
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_entry;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                         : wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                         : rd_ptr_ff + QPTR_BITS'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + QCNT_BITS'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - QCNT_BITS'(1);
         end
      end
   end

   `CHC_ASSERT_NEVER(a_queue_occupancy, clock, reset, cnt_ff > QCNT_BITS'(QUEUE_DEPTH))

endmodule

@@ rtl/chc_back.sv @@
// ----------------------------------------------------------------------------
// Hull engine
// Stores points, runs the lower and upper monotone chain passes with a
// cross-product test, and emits the hull vertices.
// ----------------------------------------------------------------------------
`include "monotone_chain_convex_hull_unit_macros.svh"

module chc_back
   import chc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   output logic      q_ready,
   input  entry_type q_entry,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output coord_type rsp_hull_x,
   output coord_type rsp_hull_y,
   output logic      rsp_final_vertex,
   output logic      rsp_dropped_points
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_CHECK,
      ST_MUL,
      ST_CMP,
      ST_RELOAD,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   state_type                    state_ff;
   logic [PT_CNT_BITS-1:0]       cnt_ff;
   logic                         ovf_ff;
   logic [PT_IDX_BITS-1:0]       idx_ff;
   logic                         upper_ff;
   logic [STK_CNT_BITS-1:0]      t_ff;
   logic [STK_CNT_BITS-1:0]      lower_ff;
   logic [STK_IDX_BITS-1:0]      emit_ff;
   point_type                    top_ff;
   point_type                    sec_ff;
   point_type                    cand_ff;
   logic signed [DIFF_BITS-1:0]  dx1_ff;
   logic signed [DIFF_BITS-1:0]  dy1_ff;
   logic signed [DIFF_BITS-1:0]  dx2_ff;
   logic signed [DIFF_BITS-1:0]  dy2_ff;
   logic signed [PROD_BITS-1:0]  p1_ff;
   logic signed [PROD_BITS-1:0]  p2_ff;
   logic                         out_valid_ff;
   point_type                    out_pt_ff;
   logic                         out_last_ff;
   logic                         out_drop_ff;

   logic [STK_CNT_BITS-1:0]      lim;
   logic                         push_go;
   logic                         lower_last;
   logic                         load_out;
   logic                         pt_wr_en;
   logic [POINT_BITS-1:0]        pt_rd;
   logic [STK_IDX_BITS-1:0]      stk_rd_addr;
   logic [POINT_BITS-1:0]        stk_rd;

   // Pop floor: one entry in the lower pass, the lower hull in the upper pass
   assign lim        = upper_ff ? lower_ff : STK_CNT_BITS'(1);
   assign lower_last = (PT_CNT_BITS'(idx_ff) + PT_CNT_BITS'(1) == cnt_ff);
   assign push_go    = ((state_ff == ST_CHECK) && !(t_ff > lim)) ||
                       ((state_ff == ST_CMP) && !(p1_ff <= p2_ff));
   assign load_out   = (state_ff == ST_EMIT_LD) && (!out_valid_ff || rsp_ready);
   assign q_ready    = (state_ff == ST_IDLE);
   assign pt_wr_en   = (state_ff == ST_IDLE) && q_valid && q_entry.keep;

   // Stack read: the new second entry during a pop, else the emit pointer
   assign stk_rd_addr = ((state_ff == ST_EMIT_RD) || (state_ff == ST_EMIT_LD)) ? emit_ff
                        : STK_IDX_BITS'(t_ff - STK_CNT_BITS'(3));

   chc_ram #(
      .WIDTH (POINT_BITS),
      .DEPTH (MAX_POINTS)
   ) u_point_store (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (cnt_ff[PT_IDX_BITS-1:0]),
      .wr_data (q_entry.pt),
      .rd_addr (idx_ff),
      .rd_data (pt_rd)
   );

   chc_ram #(
      .WIDTH (POINT_BITS),
      .DEPTH (STACK_DEPTH)
   ) u_hull_stack (
      .clock   (clock),
      .wr_en   (push_go),
      .wr_addr (t_ff[STK_IDX_BITS-1:0]),
      .wr_data (cand_ff),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd)
   );

   // Sequencer, datapath and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         upper_ff     <= 1'b0;
         t_ff         <= '0;
         lower_ff     <= '0;
         emit_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  if (q_entry.keep) begin
                     cnt_ff <= cnt_ff + PT_CNT_BITS'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (q_entry.last) begin
                     idx_ff   <= '0;
                     upper_ff <= 1'b0;
                     t_ff     <= '0;
                     state_ff <= ST_FETCH;
                  end
               end
            end
            ST_FETCH: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               cand_ff  <= point_type'(pt_rd);
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               // Form the edge vectors of the turn test
               if (!push_go) begin
                  dx1_ff   <= DIFF_BITS'($signed(top_ff.x)) - DIFF_BITS'($signed(sec_ff.x));
                  dy1_ff   <= DIFF_BITS'($signed(top_ff.y)) - DIFF_BITS'($signed(sec_ff.y));
                  dx2_ff   <= DIFF_BITS'($signed(cand_ff.x)) - DIFF_BITS'($signed(top_ff.x));
                  dy2_ff   <= DIFF_BITS'($signed(cand_ff.y)) - DIFF_BITS'($signed(top_ff.y));
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               p1_ff    <= PROD_BITS'(dx1_ff) * PROD_BITS'(dy2_ff);
               p2_ff    <= PROD_BITS'(dy1_ff) * PROD_BITS'(dx2_ff);
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               // Clockwise or collinear turn: drop the stack top
               if (!push_go) begin
                  t_ff   <= t_ff - STK_CNT_BITS'(1);
                  top_ff <= sec_ff;
                  if ((t_ff - STK_CNT_BITS'(1)) > lim) begin
                     state_ff <= ST_RELOAD;
                  end else begin
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_RELOAD: begin
               sec_ff   <= point_type'(stk_rd);
               state_ff <= ST_CHECK;
            end
            ST_EMIT_RD: begin
               // All vertices but the closing one emitted: clear for the next set
               if (STK_CNT_BITS'(emit_ff) + STK_CNT_BITS'(1) >= t_ff) begin
                  cnt_ff   <= '0;
                  ovf_ff   <= 1'b0;
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_EMIT_LD;
               end
            end
            ST_EMIT_LD: begin
               if (load_out) begin
                  emit_ff  <= emit_ff + STK_IDX_BITS'(1);
                  state_ff <= ST_EMIT_RD;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         // Push the candidate and advance to the next one
         if (push_go) begin
            sec_ff <= top_ff;
            top_ff <= cand_ff;
            t_ff   <= t_ff + STK_CNT_BITS'(1);
            if (!upper_ff) begin
               if (lower_last) begin
                  lower_ff <= t_ff + STK_CNT_BITS'(1);
                  upper_ff <= 1'b1;
                  if (cnt_ff == PT_CNT_BITS'(1)) begin
                     emit_ff  <= '0;
                     state_ff <= ST_EMIT_RD;
                  end else begin
                     idx_ff   <= idx_ff - PT_IDX_BITS'(1);
                     state_ff <= ST_FETCH;
                  end
               end else begin
                  idx_ff   <= idx_ff + PT_IDX_BITS'(1);
                  state_ff <= ST_FETCH;
               end
            end else if (idx_ff == '0) begin
               emit_ff  <= '0;
               state_ff <= ST_EMIT_RD;
            end else begin
               idx_ff   <= idx_ff - PT_IDX_BITS'(1);
               state_ff <= ST_FETCH;
            end
         end

         // Hold the result word until taken
         if (load_out) begin
            out_valid_ff <= 1'b1;
            out_pt_ff    <= point_type'(stk_rd);
            out_last_ff  <= (STK_CNT_BITS'(emit_ff) + STK_CNT_BITS'(2) == t_ff);
            out_drop_ff  <= ovf_ff;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_hull_x         = out_pt_ff.x;
   assign rsp_hull_y         = out_pt_ff.y;
   assign rsp_final_vertex   = out_last_ff;
   assign rsp_dropped_points = out_drop_ff;

   `CHC_ASSERT_NEVER(a_point_count_cap, clock, reset, cnt_ff > PT_CNT_BITS'(MAX_POINTS))
   `CHC_ASSERT_IMPL(a_upper_floor, clock, reset, upper_ff && (state_ff != ST_IDLE), t_ff >= lower_ff)
   `CHC_ASSERT_IMPL(a_stack_room, clock, reset, push_go, t_ff <= STK_CNT_BITS'(STACK_DEPTH - 2))

endmodule

@@ rtl/monotone_chain_convex_hull_unit.sv @@
// ----------------------------------------------------------------------------
// Monotone chain convex hull unit
// Collects a sorted point set and returns its convex hull vertices in order.
//
//   channel  prefix  direction  payload
//   points   req_    in         px, py, final_point
//   hull     rsp_    out        hull_x, hull_y, final_vertex, dropped_points
//
// Points are taken one per cycle through a two-word queue while the engine is
// idle. After the last point it fetches each candidate (FETCH, LOAD), pushes
// it if the stack is at its floor, else runs the turn test (CHECK, MUL, CMP);
// a pop above the floor reloads the second (RELOAD), as the RAMs are registered.
// Each vertex passes EMIT_RD and EMIT_LD, and a last EMIT_RD closes the set.
// Reset is synchronous and active high; the output register holds a vertex
// under stall while the engine waits.
// ----------------------------------------------------------------------------
module monotone_chain_convex_hull_unit
   import chc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  coord_type req_px,
   input  coord_type req_py,
   input  logic      req_final_point,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output coord_type rsp_hull_x,
   output coord_type rsp_hull_y,
   output logic      rsp_final_vertex,
   output logic      rsp_dropped_points
);

   logic      fq_valid;
   logic      fq_ready;
   entry_type fq_entry;
   logic      qb_valid;
   logic      qb_ready;
   entry_type qb_entry;

   chc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_px          (req_px),
      .req_py          (req_py),
      .req_final_point (req_final_point),
      .q_valid         (fq_valid),
      .q_ready         (fq_ready),
      .q_entry         (fq_entry)
   );

   chc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_entry  (fq_entry),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_entry (qb_entry)
   );

   chc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (qb_valid),
      .q_ready            (qb_ready),
      .q_entry            (qb_entry),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hull_x         (rsp_hull_x),
      .rsp_hull_y         (rsp_hull_y),
      .rsp_final_vertex   (rsp_final_vertex),
      .rsp_dropped_points (rsp_dropped_points)
   );

endmodule

@@ dv/monotone_chain_convex_hull_checker.sv @@
// ----------------------------------------------------------------------------
// Convex hull unit checker
// Watches the point and hull channels of the hull unit. It keeps its own copy
// of each point set, runs the monotone chain on every closed set to predict
// the hull words, and compares each accepted hull word with the oldest one
// still waiting. It reports the failure count and the number of words waiting.
// ----------------------------------------------------------------------------
module monotone_chain_convex_hull_checker
   import chc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      req_ready,
   input  coord_type req_px,
   input  coord_type req_py,
   input  logic      req_final_point,
   input  logic      rsp_valid,
   input  logic      rsp_ready,
   input  coord_type rsp_hull_x,
   input  coord_type rsp_hull_y,
   input  logic      rsp_final_vertex,
   input  logic      rsp_dropped_points,
   output int        fail_count,
   output int        vertices_pending,
   output int        vertices_checked
);

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      final_vertex;
      logic      dropped;
   } hull_vertex_type;

   // Shadow copy of the set being loaded
   coord_type    set_x [MAX_POINTS];
   coord_type    set_y [MAX_POINTS];
   int           set_count    = 0;
   logic         set_overflow = 1'b0;

   // Hull words predicted but not yet seen
   hull_vertex_type hull_vertex_q [$];

   // True when b -> a -> c does not turn strictly left
   function automatic logic turn_not_left(input int b, input int a, input int c);
      longint dx1, dy1, dx2, dy2;
      dx1 = longint'(set_x[a]) - longint'(set_x[b]);
      dy1 = longint'(set_y[a]) - longint'(set_y[b]);
      dx2 = longint'(set_x[c]) - longint'(set_x[a]);
      dy2 = longint'(set_y[c]) - longint'(set_y[a]);
      return (dx1 * dy2 - dy1 * dx2) <= 0;
   endfunction

   // Build lower then upper chain and queue the hull words of the set
   task automatic close_set();
      int              chain [STACK_DEPTH];
      int              depth;
      int              lower;
      int              k;
      hull_vertex_type v;
      depth = 0;
      for (int i = 0; i < set_count; i++) begin
         while (depth > 1 && turn_not_left(chain[depth-2], chain[depth-1], i))
            depth--;
         if (depth < STACK_DEPTH) begin
            chain[depth] = i;
            depth++;
         end
      end
      lower = depth;
      for (int i = set_count - 2; i >= 0; i--) begin
         while (depth > lower && turn_not_left(chain[depth-2], chain[depth-1], i))
            depth--;
         if (depth < STACK_DEPTH) begin
            chain[depth] = i;
            depth++;
         end
      end
      // Drop the repeated start vertex at the end of the upper chain
      k = (depth > 0) ? depth - 1 : 0;
      for (int i = 0; i < k; i++) begin
         v.x            = set_x[chain[i] % MAX_POINTS];
         v.y            = set_y[chain[i] % MAX_POINTS];
         v.final_vertex = (i + 1 == k);
         v.dropped      = set_overflow;
         hull_vertex_q.push_back(v);
      end
      set_count    = 0;
      set_overflow = 1'b0;
   endtask

   always @(posedge clock) begin : watch_channels
      hull_vertex_type want;
      if (reset) begin
         set_count    = 0;
         set_overflow = 1'b0;
         hull_vertex_q.delete();
      end else begin
         // Compare an accepted hull word with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (hull_vertex_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected hull word: x=%0d y=%0d final=%0b dropped=%0b",
                           rsp_hull_x, rsp_hull_y, rsp_final_vertex, rsp_dropped_points);
               fail_count = fail_count + 1;
            end else begin
               want = hull_vertex_q.pop_front();
               vertices_checked = vertices_checked + 1;
               if (rsp_hull_x !== want.x || rsp_hull_y !== want.y ||
                   rsp_final_vertex !== want.final_vertex ||
                   rsp_dropped_points !== want.dropped) begin
                  if (fail_count < 10) begin
                     $display("hull word mismatch: expected x=%0d y=%0d final=%0b dropped=%0b",
                              want.x, want.y, want.final_vertex, want.dropped);
                     $display("                    got      x=%0d y=%0d final=%0b dropped=%0b",
                              rsp_hull_x, rsp_hull_y, rsp_final_vertex, rsp_dropped_points);
                  end
                  fail_count = fail_count + 1;
               end
            end
         end
         // Store an accepted point, or flag it once the set is full
         if (req_valid && req_ready) begin
            if (set_count < MAX_POINTS) begin
               set_x[set_count] = req_px;
               set_y[set_count] = req_py;
               set_count = set_count + 1;
            end else begin
               set_overflow = 1'b1;
            end
            if (req_final_point)
               close_set();
         end
      end
      vertices_pending = hull_vertex_q.size();
   end

endmodule

@@ dv/monotone_chain_convex_hull_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Convex hull unit testbench
// Drives mostly sorted point sets into the hull unit: a few hand-picked sets
// (one point, twin points, corner extremes, collinear and unsorted input), then
// random sets of spread, grid and extreme points, some over capacity. Both
// channels idle at random; one long receiver hold-off backs the unit up.
// ----------------------------------------------------------------------------
module monotone_chain_convex_hull_unit_tb;
   import chc_pkg::*;

   typedef enum int {
      SET_SPREAD,
      SET_GRID,
      SET_EXTREME,
      SET_SHUFFLED
   } set_mode_type;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_LEN   = 300;
   localparam int SETTLE_CYCLES  = 60;
   localparam int RANDOM_POINTS  = 190;

   logic      clock              = 1'b0;
   logic      reset              = 1'b1;
   logic      req_valid          = 1'b0;
   logic      req_ready;
   coord_type req_px             = '0;
   coord_type req_py             = '0;
   logic      req_final_point    = 1'b0;
   logic      rsp_valid;
   logic      rsp_ready          = 1'b0;
   coord_type rsp_hull_x;
   coord_type rsp_hull_y;
   logic      rsp_final_vertex;
   logic      rsp_dropped_points;

   int        fail_count;
   int        vertices_pending;
   int        vertices_checked;

   // Stimulus knobs and bookkeeping
   int        send_idle_max  = 11;
   int        recv_idle_max  = 11;
   int        hold_off       = 0;
   int        idle_cycles    = 0;
   int        sets_sent      = 0;
   int        points_sent    = 0;
   int        overflow_sets  = 0;
   coord_type pt_x [$];
   coord_type pt_y [$];

   monotone_chain_convex_hull_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_px             (req_px),
      .req_py             (req_py),
      .req_final_point    (req_final_point),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hull_x         (rsp_hull_x),
      .rsp_hull_y         (rsp_hull_y),
      .rsp_final_vertex   (rsp_final_vertex),
      .rsp_dropped_points (rsp_dropped_points)
   );

   monotone_chain_convex_hull_checker hull_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_px             (req_px),
      .req_py             (req_py),
      .req_final_point    (req_final_point),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hull_x         (rsp_hull_x),
      .rsp_hull_y         (rsp_hull_y),
      .rsp_final_vertex   (rsp_final_vertex),
      .rsp_dropped_points (rsp_dropped_points),
      .fail_count         (fail_count),
      .vertices_pending   (vertices_pending),
      .vertices_checked   (vertices_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // End the run when no word moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("** monotone_chain_convex_hull_unit: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: hold ready low for a random count, or a long hold-off on request
   initial begin : hull_receiver
      int wait_len;
      while (reset) @(negedge clock);
      forever begin
         if (hold_off > 0) begin
            wait_len = hold_off;
            hold_off = 0;
         end else begin
            wait_len = $urandom_range(0, recv_idle_max);
         end
         if (wait_len > 0) begin
            @(negedge clock) rsp_ready <= 1'b0;
            repeat (wait_len - 1) @(negedge clock);
         end
         @(negedge clock) rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid && hold_off == 0);
      end
   end

   // Offer one point word after a random gap and hold it until accepted
   task automatic send_point(input coord_type x, input coord_type y, input logic last);
      int gap;
      gap = $urandom_range(0, send_idle_max);
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_px          <= x;
      req_py          <= y;
      req_final_point <= last;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      points_sent = points_sent + 1;
   endtask

   // Send the staged set, last point marked
   task automatic send_set();
      if (pt_x.size() > MAX_POINTS)
         overflow_sets = overflow_sets + 1;
      for (int i = 0; i < pt_x.size(); i++)
         send_point(pt_x[i], pt_y[i], i == pt_x.size() - 1);
      sets_sent = sets_sent + 1;
   endtask

   // Pause the sender until every predicted hull word has arrived
   task automatic wait_for_hull();
      @(negedge clock) req_valid <= 1'b0;
      while (vertices_pending != 0) @(negedge clock);
   endtask

   // Stage a random set of n points, sorted by x then y unless shuffled
   task automatic build_set(input int n, input set_mode_type mode);
      int        extremes [7];
      int        cx;
      int        cy;
      int        j;
      coord_type tx;
      coord_type ty;
      extremes = '{-32768, -32767, -1, 0, 1, 32766, 32767};
      cx = $urandom_range(0, 60000) - 30000;
      cy = $urandom_range(0, 60000) - 30000;
      pt_x.delete();
      pt_y.delete();
      for (int i = 0; i < n; i++) begin
         case (mode)
            SET_GRID: begin
               pt_x.push_back(coord_type'(cx + $urandom_range(0, 6) - 3));
               pt_y.push_back(coord_type'(cy + $urandom_range(0, 6) - 3));
            end
            SET_EXTREME: begin
               pt_x.push_back(coord_type'(extremes[$urandom_range(0, 6)]));
               pt_y.push_back(coord_type'(extremes[$urandom_range(0, 6)]));
            end
            default: begin
               pt_x.push_back(coord_type'($urandom_range(0, 65535)));
               pt_y.push_back(coord_type'($urandom_range(0, 65535)));
            end
         endcase
      end
      if (mode != SET_SHUFFLED) begin
         for (int i = 1; i < n; i++) begin
            j = i;
            while (j > 0 && (pt_x[j-1] > pt_x[j] ||
                             (pt_x[j-1] == pt_x[j] && pt_y[j-1] > pt_y[j]))) begin
               tx = pt_x[j-1];
               ty = pt_y[j-1];
               pt_x[j-1] = pt_x[j];
               pt_y[j-1] = pt_y[j];
               pt_x[j] = tx;
               pt_y[j] = ty;
               j--;
            end
         end
      end
   endtask

   initial begin : point_sender
      int           random_points;
      int           set_idx;
      int           n;
      int           pick;
      set_mode_type mode;
      random_points = 0;
      set_idx       = 0;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Single point: no hull words
      pt_x = '{0};
      pt_y = '{0};
      send_set();
      // Two identical points: both come back
      pt_x = '{5, 5};
      pt_y = '{-7, -7};
      send_set();
      // Corners of the coordinate range
      pt_x = '{-32768, -32768, 32767, 32767};
      pt_y = '{-32768, 32767, -32768, 32767};
      send_set();
      // Collinear run
      pt_x = '{-1, 0, 1};
      pt_y = '{-1, 0, 1};
      send_set();
      // Triangle with an edge point and a duplicate
      pt_x = '{-10, 0, 0, 0, 10};
      pt_y = '{0, 0, 0, 5, 0};
      send_set();
      // Unsorted input runs through the same chain
      pt_x = '{100, -100, 100, -100};
      pt_y = '{100, -100, -100, 100};
      send_set();
      wait_for_hull();

      // Random sets: mostly small, a few over capacity
      while (random_points < RANDOM_POINTS) begin
         send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
         recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
         pick = $urandom_range(0, 9);
         if (pick < 4)
            mode = SET_SPREAD;
         else if (pick < 7)
            mode = SET_GRID;
         else if (pick < 9)
            mode = SET_EXTREME;
         else
            mode = SET_SHUFFLED;
         if (set_idx == 4 || set_idx == 12)
            n = MAX_POINTS + 1 + $urandom_range(0, 3);
         else if ($urandom_range(0, 7) == 0)
            n = $urandom_range(9, 20);
         else
            n = $urandom_range(1, 8);
         // Back the unit up: stall the hull side while points keep coming
         if (set_idx == 6 || set_idx == 7) begin
            send_idle_max = 0;
            n = 6;
            if (set_idx == 6) begin
               mode = SET_SPREAD;
               hold_off = HOLD_OFF_LEN;
            end
         end
         build_set(n, mode);
         send_set();
         random_points = random_points + n;
         set_idx = set_idx + 1;
         if (set_idx != 7 && $urandom_range(0, 4) == 0)
            wait_for_hull();
      end

      // Drain and let the unit settle
      wait_for_hull();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d point sets, %0d points (%0d sets over capacity)",
               sets_sent, points_sent, overflow_sets);
      $display("checked %0d hull words under random idling and a %0d-cycle hull-side hold-off",
               vertices_checked, HOLD_OFF_LEN);
      if (fail_count == 0) begin
         $display("** monotone_chain_convex_hull_unit: PASSED **");
      end else begin
         $display("%0d failures", fail_count);
         $display("** monotone_chain_convex_hull_unit: FAILED **");
      end
      $finish;
   end

endmodule
